// ===== design/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude: shared types and helpers
// Pixel and window types, stage control, gradient and square root steps.
// ----------------------------------------------------------------------------
package sem_pkg;

	typedef logic [23:0] pixel_t;
	typedef logic [8:0][23:0] window_t;
	typedef logic signed [10:0] grad_t;
	typedef logic [20:0] energy_t;

	typedef struct packed {
		logic valid;
		logic last;
	} stage_ctl_t;

	typedef struct packed {
		logic        sat;
		logic [15:0] rad;
		logic [10:0] rem;
		logic [7:0]  root;
	} root_lane_t;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 11;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
	localparam int CFG_DIM_RESET = 1024;

	localparam logic [7:0] EDGE_MAX  = 8'd255;
	localparam energy_t    SAT_LEVEL = 21'd65281;

	// (a + 2b + c) - (d + 2e + f)
	function automatic grad_t grad(logic [7:0] a, logic [7:0] b, logic [7:0] c,
			logic [7:0] d, logic [7:0] e, logic [7:0] f);
		logic [9:0] pos;
		logic [9:0] neg;
		pos = 10'(a) + {1'b0, b, 1'b0} + 10'(c);
		neg = 10'(d) + {1'b0, e, 1'b0} + 10'(f);
		return $signed({1'b0, pos}) - $signed({1'b0, neg});
	endfunction

	function automatic root_lane_t root_init(energy_t s);
		root_lane_t y;
		y.sat  = (s >= SAT_LEVEL);
		y.rad  = s[15:0];
		y.rem  = '0;
		y.root = '0;
		return y;
	endfunction

	// one digit of the restoring square root
	function automatic root_lane_t root_step(root_lane_t x);
		root_lane_t y;
		logic [10:0] part;
		logic [10:0] trial;
		part  = {x.rem[8:0], x.rad[15:14]};
		trial = {1'b0, x.root, 2'b01};
		y     = x;
		y.rad = {x.rad[13:0], 2'b00};
		if (part >= trial) begin
			y.rem  = part - trial;
			y.root = {x.root[6:0], 1'b1};
		end else begin
			y.rem  = part;
			y.root = {x.root[6:0], 1'b0};
		end
		return y;
	endfunction

	function automatic root_lane_t root_pair(root_lane_t x);
		return root_step(root_step(x));
	endfunction

endpackage

// ===== design/sobel_edge_magnitude.sv =====
// A result passes the window, gradient, square and root stage registers into the output
// register; a drain of a one-row frame has to step a second position first.
// Throughput: one request per cycle unless the output stalls or a drain at the row wrap of a
// one-row frame steps a second position, as line memory is read and written once per position.
// A stalled result holds the whole pipeline and the input.
// Reset: positions, pending count and window clear, dimensions return to 1024 (or the
// maximum); the line memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Streaming 3x3 Sobel gradient magnitude per RGB channel, rounded and
// clamped to 255, with zero padding outside the frame.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            operation,
	input  logic [7:0]                      pixel_red,
	input  logic [7:0]                      pixel_green,
	input  logic [7:0]                      pixel_blue,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      edge_red,
	output logic [7:0]                      edge_green,
	output logic [7:0]                      edge_blue,
	output logic                            last_of_frame,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                 adv;
	logic                 take;
	logic                 busy;
	sem_pkg::window_t     win_s1;
	sem_pkg::stage_ctl_t  ctl_s1;
	logic [7:0]           res_edge [3];

	// advance the pipeline unless a result waits on a stalled output
	assign adv       = !out_valid || !out_stall;
	assign in_stall  = !adv || busy;
	assign take      = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	sem_line_window #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.take      (take),
		.op        (operation),
		.pixel     ({pixel_red, pixel_green, pixel_blue}),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.win_s1    (win_s1),
		.ctl_s1    (ctl_s1)
	);

	sem_magnitude u_magnitude (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.win_s1    (win_s1),
		.ctl_s1    (ctl_s1),
		.res_valid (out_valid),
		.res_last  (last_of_frame),
		.res_edge  (res_edge)
	);

	assign edge_red   = res_edge[0];
	assign edge_green = res_edge[1];
	assign edge_blue  = res_edge[2];

endmodule

// ===== design/sem_line_window.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude: line memory and window
// Keeps the two previous rows in one line memory, the 3x3 window, the
// frame position and the count of results still owed.
// ----------------------------------------------------------------------------
module sem_line_window #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              take,
	input  logic                              op,
	input  sem_pkg::pixel_t                   pixel,
	input  logic                              cfg_write,
	input  logic [sem_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              busy,
	output sem_pkg::window_t                  win_s1,
	output sem_pkg::stage_ctl_t               ctl_s1
);

	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int DW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 2);
	localparam int PW    = $clog2(MAX_WIDTH + 2);
	localparam int W_RST = (MAX_WIDTH < sem_pkg::CFG_DIM_RESET) ?
		MAX_WIDTH : sem_pkg::CFG_DIM_RESET;
	localparam int H_RST = (MAX_HEIGHT < sem_pkg::CFG_DIM_RESET) ?
		MAX_HEIGHT : sem_pkg::CFG_DIM_RESET;

	function automatic int unsigned clamp_dim(logic [sem_pkg::CFG_DATA_W-1:0] v,
			int unsigned maxv);
		if (v == '0) return 1;
		if (int'(v) > maxv) return maxv;
		return int'(v);
	endfunction

	logic [47:0] line_mem [MAX_WIDTH];

	logic [DW-1:0]     w_q;
	logic [RW-1:0]     h_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [PW-1:0]     pend_q;
	logic              redo_q;
	sem_pkg::pixel_t   col1_q [3];
	sem_pkg::pixel_t   col2_q [3];
	logic [47:0]       rd_q;
	logic              fwd_q;
	logic [47:0]       fwd_data_q;

	logic [47:0]       line;
	logic [47:0]       wdata;
	sem_pkg::pixel_t   newc [3];
	logic              complete;
	logic [RW:0]       r_ext;
	logic [RW:0]       h_ext;
	logic              top_ok;
	logic              mid_ok;
	logic              pixel_go;
	logic              drain_go;
	logic              step;
	logic              produce;
	logic [PW-1:0]     pend_inc;
	logic [PW-1:0]     pend_after;
	logic              last;
	logic [DW-1:0]     c_inc;
	logic              wrap;
	logic              restart;
	logic [CW-1:0]     col_n;
	logic [RW-1:0]     row_n;
	sem_pkg::window_t  win_n;

	always_comb begin
		line     = fwd_q ? fwd_data_q : rd_q;
		complete = (row_q >= h_q);
		r_ext    = {1'b0, row_q};
		h_ext    = {1'b0, h_q};
		top_ok   = (r_ext >= (RW+1)'(2)) && (r_ext < h_ext + (RW+1)'(2));
		mid_ok   = (r_ext >= (RW+1)'(1)) && (r_ext < h_ext + (RW+1)'(1));
		newc[0]  = top_ok ? line[47:24] : '0;
		newc[1]  = mid_ok ? line[23:0] : '0;
		newc[2]  = complete ? '0 : pixel;
		wdata    = {line[23:0], newc[2]};

		pixel_go = take && !complete && (op == sem_pkg::OP_PIXEL);
		drain_go = take && complete && (pend_q != '0);
		step     = adv && (redo_q || pixel_go || drain_go);
		produce  = (col_q == '0) ? (row_q >= RW'(2)) : (row_q >= RW'(1));

		pend_inc   = pend_q + PW'(pixel_go);
		pend_after = (produce && (pend_inc != '0)) ? pend_inc - PW'(1) : pend_inc;
		last       = (pend_after == '0);

		c_inc   = DW'(col_q) + DW'(1);
		wrap    = (c_inc == w_q);
		restart = cfg_write || (step && produce && last);

		if (restart) begin
			col_n = '0;
			row_n = '0;
		end else if (step) begin
			col_n = wrap ? '0 : CW'(c_inc);
			row_n = wrap ? row_q + RW'(1) : row_q;
		end else begin
			col_n = col_q;
			row_n = row_q;
		end

		for (int r = 0; r < 3; r++) begin
			win_n[r*3+0] = col1_q[r];
			win_n[r*3+1] = col2_q[r];
			win_n[r*3+2] = (col_q == '0) ? '0 : newc[r];
		end
	end

	assign busy = redo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= DW'(W_RST);
			h_q    <= RW'(H_RST);
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
			redo_q <= 1'b0;
			fwd_q  <= 1'b0;
			ctl_s1 <= '0;
			for (int r = 0; r < 3; r++) begin
				col1_q[r] <= '0;
				col2_q[r] <= '0;
			end
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					sem_pkg::CFG_FRAME_WIDTH:  w_q <= DW'(clamp_dim(cfg_data, MAX_WIDTH));
					sem_pkg::CFG_FRAME_HEIGHT: h_q <= RW'(clamp_dim(cfg_data, MAX_HEIGHT));
					default: ;
				endcase
			end
			col_q <= col_n;
			row_q <= row_n;
			// forward the entry just written when the next read hits it
			fwd_q <= step && (col_q == col_n);
			if (restart) begin
				pend_q <= '0;
				redo_q <= 1'b0;
				for (int r = 0; r < 3; r++) begin
					col1_q[r] <= '0;
					col2_q[r] <= '0;
				end
			end else if (step) begin
				pend_q <= pend_after;
				// a drain that gives nothing advances once more
				redo_q <= !redo_q && complete && !produce;
				for (int r = 0; r < 3; r++) begin
					col1_q[r] <= (col_q == '0) ? '0 : col2_q[r];
					col2_q[r] <= newc[r];
				end
			end
			if (adv) begin
				ctl_s1.valid <= step && produce;
				ctl_s1.last  <= last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			line_mem[col_q] <= wdata;
		end
		rd_q       <= line_mem[col_n];
		fwd_data_q <= wdata;
		if (adv) begin
			win_s1 <= win_n;
		end
	end

endmodule

// ===== design/sem_magnitude.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude: gradient and rounded root pipeline
// Gx and Gy per channel, sum of squares, then a two-digit-per-stage
// square root with rounding into the result register.
// ----------------------------------------------------------------------------
module sem_magnitude (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  sem_pkg::window_t     win_s1,
	input  sem_pkg::stage_ctl_t  ctl_s1,
	output logic                 res_valid,
	output logic                 res_last,
	output logic [7:0]           res_edge [3]
);

	sem_pkg::stage_ctl_t  ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	sem_pkg::grad_t       gx_s2 [3];
	sem_pkg::grad_t       gy_s2 [3];
	sem_pkg::energy_t     sq_s3 [3];
	sem_pkg::root_lane_t  lane_s4 [3];
	sem_pkg::root_lane_t  lane_s5 [3];
	sem_pkg::root_lane_t  lane_s6 [3];
	sem_pkg::root_lane_t  lane_s7 [3];

	logic [7:0]           p [3][9];
	logic signed [21:0]   sqx [3];
	logic signed [21:0]   sqy [3];
	logic [21:0]          tot [3];
	logic [8:0]           rounded [3];
	logic [7:0]           edge_n [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 9; i++) begin
				p[ch][i] = win_s1[i][23-8*ch -: 8];
			end
			sqx[ch] = gx_s2[ch] * gx_s2[ch];
			sqy[ch] = gy_s2[ch] * gy_s2[ch];
			tot[ch] = $unsigned(sqx[ch]) + $unsigned(sqy[ch]);
			// round up when s exceeds q*q + q, i.e. remainder above q
			rounded[ch] = {1'b0, lane_s7[ch].root} +
				9'(lane_s7[ch].rem > 11'(lane_s7[ch].root));
			edge_n[ch] = lane_s7[ch].sat ? sem_pkg::EDGE_MAX : rounded[ch][7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2    <= '0;
			ctl_s3    <= '0;
			ctl_s4    <= '0;
			ctl_s5    <= '0;
			ctl_s6    <= '0;
			ctl_s7    <= '0;
			res_valid <= 1'b0;
			res_last  <= 1'b0;
		end else if (adv) begin
			ctl_s2    <= ctl_s1;
			ctl_s3    <= ctl_s2;
			ctl_s4    <= ctl_s3;
			ctl_s5    <= ctl_s4;
			ctl_s6    <= ctl_s5;
			ctl_s7    <= ctl_s6;
			res_valid <= ctl_s7.valid;
			res_last  <= ctl_s7.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				gx_s2[ch] <= sem_pkg::grad(p[ch][2], p[ch][5], p[ch][8],
					p[ch][0], p[ch][3], p[ch][6]);
				gy_s2[ch] <= sem_pkg::grad(p[ch][6], p[ch][7], p[ch][8],
					p[ch][0], p[ch][1], p[ch][2]);
				sq_s3[ch]    <= tot[ch][20:0];
				lane_s4[ch]  <= sem_pkg::root_pair(sem_pkg::root_init(sq_s3[ch]));
				lane_s5[ch]  <= sem_pkg::root_pair(lane_s4[ch]);
				lane_s6[ch]  <= sem_pkg::root_pair(lane_s5[ch]);
				lane_s7[ch]  <= sem_pkg::root_pair(lane_s6[ch]);
				res_edge[ch] <= edge_n[ch];
			end
		end
	end

endmodule
